>>> hw/rtl/jdate_pkg.sv
// Shared types, constants and the month length table for the day number to date converter.
package jdate_pkg;

   localparam int DAY_W   = 40;
   localparam int REM_W   = 18;
   localparam int QUO_W   = 23;
   localparam int YEAR_W  = 32;
   localparam int SHORT_W = 21;
   localparam int MUL_A_W = 32;
   localparam int RECIP_W = 24;
   localparam int PROD_W  = MUL_A_W + RECIP_W;
   localparam int BACK_W  = QUO_W + REM_W;

   // Quotient positions in the reciprocal product for the long and the short dividend.
   localparam int SHIFT_LONG  = 33;
   localparam int SHIFT_SHORT = 34;

   localparam logic [DAY_W-1:0] JULIAN_AD_START = 40'd1721424;
   localparam logic [DAY_W-1:0] GREGORIAN_START = 40'd2299161;
   localparam logic [DAY_W-1:0] GREGORIAN_EPOCH = 40'd1721426;

   localparam logic [REM_W-1:0] DAYS_400Y = 18'd146097;
   localparam logic [REM_W-1:0] DAYS_100Y = 18'd36524;
   localparam logic [REM_W-1:0] DAYS_4Y   = 18'd1461;
   localparam logic [REM_W-1:0] DAYS_1Y   = 18'd365;
   localparam logic [REM_W-1:0] DAYS_LY   = 18'd366;

   // Truncated reciprocals: the estimate they give is the true quotient or one less.
   localparam logic [RECIP_W-1:0] RECIP_400Y =
      RECIP_W'((64'd1 << (SHIFT_LONG + DAY_W - MUL_A_W)) / 64'(DAYS_400Y));
   localparam logic [RECIP_W-1:0] RECIP_4Y =
      RECIP_W'((64'd1 << SHIFT_SHORT) / 64'(DAYS_4Y));

   localparam logic [YEAR_W-1:0] BC_FIRST_YEAR = 32'd4713;

   localparam logic [1:0] CENT_CAP  = 2'd3;
   localparam logic [4:0] QUAD_CAP  = 5'd24;
   localparam logic [1:0] YEAR_CAP  = 2'd3;
   localparam logic [3:0] MONTH_CAP = 4'd11;
   localparam logic [3:0] FEBRUARY  = 4'd1;

   typedef enum logic [1:0] {
      RANGE_BC,
      RANGE_JULIAN,
      RANGE_GREGORIAN
   } range_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_MUL,
      CMD_BACK,
      CMD_SUB,
      CMD_FIX,
      CMD_INIT,
      CMD_CENT,
      CMD_QUAD,
      CMD_YEAR,
      CMD_MONTH
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_BACK,
      ST_SUB,
      ST_FIX,
      ST_INIT,
      ST_CENT,
      ST_QUAD,
      ST_YEAR,
      ST_MONTH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic gregorian;
      logic fix_take;
      logic cent_take;
      logic quad_take;
      logic year_take;
      logic month_take;
   } status_type;

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      begin
         case (month)
            FEBRUARY:                  len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
         endcase
         return len;
      end
   endfunction

endpackage

>>> hw/rtl/jdate_dp.sv
// Datapath of the day number to date converter: divider, span counters and month walk.
module jdate_dp (
   input  logic                           clock,
   input  logic [jdate_pkg::DAY_W-1:0]    req_day_number,
   input  jdate_pkg::cmd_type             cmd,
   output jdate_pkg::status_type          status,
   output logic [4:0]                     rsp_day_of_month,
   output logic [3:0]                     rsp_month_number,
   output logic [jdate_pkg::YEAR_W-1:0]   rsp_year_number,
   output logic                           rsp_before_christ
);

   jdate_pkg::range_type                range_ff, range_in;
   logic [jdate_pkg::DAY_W-1:0]         num_ff, num_in;
   logic [jdate_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [jdate_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic [jdate_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [jdate_pkg::YEAR_W-1:0]        year_ff, year_in;
   logic [1:0]                          cent_ff, cent_in;
   logic [4:0]                          quad_ff, quad_in;
   logic [1:0]                          yr_ff, yr_in;
   logic [3:0]                          mon_ff, mon_in;

   jdate_pkg::range_type                load_range;
   logic [jdate_pkg::DAY_W-1:0]         jul_off, greg_off;
   logic                                greg;
   logic [jdate_pkg::REM_W-1:0]         divisor;
   logic [jdate_pkg::DAY_W-1:0]         divisor_ext;
   logic [jdate_pkg::MUL_A_W-1:0]       mul_a;
   logic [jdate_pkg::RECIP_W-1:0]       recip;
   logic [jdate_pkg::PROD_W-1:0]        est_prod;
   logic [jdate_pkg::QUO_W-1:0]         quo_est;
   logic [jdate_pkg::BACK_W-1:0]        back_prod;
   logic [jdate_pkg::YEAR_W-1:0]        quo_ext;
   logic [jdate_pkg::REM_W-1:0]         year_len;
   logic [jdate_pkg::REM_W-1:0]         month_len;
   logic                                leap;

   assign jul_off  = req_day_number - jdate_pkg::JULIAN_AD_START;
   assign greg_off = req_day_number - jdate_pkg::GREGORIAN_EPOCH;

   always_comb begin
      if (req_day_number < jdate_pkg::JULIAN_AD_START) begin
         load_range = jdate_pkg::RANGE_BC;
      end else if (req_day_number < jdate_pkg::GREGORIAN_START) begin
         load_range = jdate_pkg::RANGE_JULIAN;
      end else begin
         load_range = jdate_pkg::RANGE_GREGORIAN;
      end
   end

   assign greg        = (range_ff == jdate_pkg::RANGE_GREGORIAN);
   assign divisor     = greg ? jdate_pkg::DAYS_400Y : jdate_pkg::DAYS_4Y;
   assign divisor_ext = jdate_pkg::DAY_W'(divisor);

   // The quotient is estimated by a reciprocal multiplication, multiplied back and
   // subtracted; the estimate can fall one short, which a single correction step fixes.
   assign mul_a    = greg ? num_ff[jdate_pkg::DAY_W-1 -: jdate_pkg::MUL_A_W] :
                            jdate_pkg::MUL_A_W'(num_ff[jdate_pkg::SHORT_W-1:0]);
   assign recip    = greg ? jdate_pkg::RECIP_400Y : jdate_pkg::RECIP_4Y;
   assign est_prod = jdate_pkg::PROD_W'(mul_a) * jdate_pkg::PROD_W'(recip);
   assign quo_est  = greg ? prod_ff[jdate_pkg::SHIFT_LONG +: jdate_pkg::QUO_W] :
                     jdate_pkg::QUO_W'(prod_ff[jdate_pkg::PROD_W-1:jdate_pkg::SHIFT_SHORT]);
   assign back_prod = jdate_pkg::BACK_W'(quo_est) * jdate_pkg::BACK_W'(divisor);

   assign quo_ext = jdate_pkg::YEAR_W'(quo_ff);

   // In BC years the leap year opens each four-year span.
   assign year_len = (range_ff == jdate_pkg::RANGE_BC && yr_ff == 2'd0) ?
                     jdate_pkg::DAYS_LY : jdate_pkg::DAYS_1Y;

   always_comb begin
      case (range_ff)
         jdate_pkg::RANGE_BC:     leap = (yr_ff == 2'd0);
         jdate_pkg::RANGE_JULIAN: leap = (yr_ff == jdate_pkg::YEAR_CAP);
         default:                 leap = (yr_ff == jdate_pkg::YEAR_CAP) &&
                                         ((quad_ff != jdate_pkg::QUAD_CAP) ||
                                          (cent_ff == jdate_pkg::CENT_CAP));
      endcase
   end

   assign month_len = jdate_pkg::REM_W'(jdate_pkg::month_days(mon_ff, leap));

   assign status.gregorian  = greg;
   assign status.fix_take   = (num_ff >= divisor_ext);
   assign status.cent_take  = (cent_ff != jdate_pkg::CENT_CAP) &&
                              (rem_ff >= jdate_pkg::DAYS_100Y);
   assign status.quad_take  = (quad_ff != jdate_pkg::QUAD_CAP) &&
                              (rem_ff >= jdate_pkg::DAYS_4Y);
   assign status.year_take  = (yr_ff != jdate_pkg::YEAR_CAP) && (rem_ff >= year_len);
   assign status.month_take = (mon_ff != jdate_pkg::MONTH_CAP) && (rem_ff >= month_len);

   always_comb begin
      range_in = range_ff;
      num_in   = num_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      year_in  = year_ff;
      cent_in  = cent_ff;
      quad_in  = quad_ff;
      yr_in    = yr_ff;
      mon_in   = mon_ff;
      case (cmd)
         jdate_pkg::CMD_LOAD: begin
            range_in = load_range;
            cent_in  = '0;
            quad_in  = '0;
            yr_in    = '0;
            mon_in   = '0;
            case (load_range)
               jdate_pkg::RANGE_BC:     num_in = req_day_number;
               jdate_pkg::RANGE_JULIAN: num_in = jul_off;
               default:                 num_in = greg_off;
            endcase
         end
         jdate_pkg::CMD_MUL: begin
            prod_in = est_prod;
         end
         jdate_pkg::CMD_BACK: begin
            quo_in  = quo_est;
            prod_in = jdate_pkg::PROD_W'(back_prod);
         end
         jdate_pkg::CMD_SUB: begin
            num_in = num_ff - prod_ff[jdate_pkg::DAY_W-1:0];
         end
         jdate_pkg::CMD_FIX: begin
            num_in = num_ff - divisor_ext;
            quo_in = quo_ff + jdate_pkg::QUO_W'(1);
         end
         jdate_pkg::CMD_INIT: begin
            rem_in = num_ff[jdate_pkg::REM_W-1:0];
            case (range_ff)
               jdate_pkg::RANGE_BC:
                  year_in = jdate_pkg::BC_FIRST_YEAR - (quo_ext << 2);
               jdate_pkg::RANGE_JULIAN:
                  year_in = (quo_ext << 2) + 32'd1;
               default:
                  year_in = (quo_ext << 8) + (quo_ext << 7) + (quo_ext << 4) + 32'd1;
            endcase
         end
         jdate_pkg::CMD_CENT: begin
            rem_in  = rem_ff - jdate_pkg::DAYS_100Y;
            year_in = year_ff + 32'd100;
            cent_in = cent_ff + 2'd1;
         end
         jdate_pkg::CMD_QUAD: begin
            rem_in  = rem_ff - jdate_pkg::DAYS_4Y;
            year_in = year_ff + 32'd4;
            quad_in = quad_ff + 5'd1;
         end
         jdate_pkg::CMD_YEAR: begin
            rem_in  = rem_ff - year_len;
            year_in = (range_ff == jdate_pkg::RANGE_BC) ? year_ff - 32'd1 : year_ff + 32'd1;
            yr_in   = yr_ff + 2'd1;
         end
         jdate_pkg::CMD_MONTH: begin
            rem_in = rem_ff - month_len;
            mon_in = mon_ff + 4'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      range_ff <= range_in;
      num_ff   <= num_in;
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      year_ff  <= year_in;
      cent_ff  <= cent_in;
      quad_ff  <= quad_in;
      yr_ff    <= yr_in;
      mon_ff   <= mon_in;
   end

   assign rsp_day_of_month  = rem_ff[4:0] + 5'd1;
   assign rsp_month_number  = mon_ff + 4'd1;
   assign rsp_year_number   = year_ff;
   assign rsp_before_christ = (range_ff == jdate_pkg::RANGE_BC);

endmodule

>>> hw/rtl/jdate_ctrl.sv
// Controller state machine that sequences the converter datapath.
module jdate_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  jdate_pkg::status_type   status,
   output jdate_pkg::cmd_type      cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   jdate_pkg::state_type            state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jdate_pkg::ST_IDLE:  if (start) state_in = jdate_pkg::ST_MUL;
         jdate_pkg::ST_MUL:   state_in = jdate_pkg::ST_BACK;
         jdate_pkg::ST_BACK:  state_in = jdate_pkg::ST_SUB;
         jdate_pkg::ST_SUB:   state_in = jdate_pkg::ST_FIX;
         jdate_pkg::ST_FIX:   if (!status.fix_take) state_in = jdate_pkg::ST_INIT;
         jdate_pkg::ST_INIT:  state_in = status.gregorian ? jdate_pkg::ST_CENT
                                                          : jdate_pkg::ST_YEAR;
         jdate_pkg::ST_CENT:  if (!status.cent_take) state_in = jdate_pkg::ST_QUAD;
         jdate_pkg::ST_QUAD:  if (!status.quad_take) state_in = jdate_pkg::ST_YEAR;
         jdate_pkg::ST_YEAR:  if (!status.year_take) state_in = jdate_pkg::ST_MONTH;
         jdate_pkg::ST_MONTH: if (!status.month_take) state_in = jdate_pkg::ST_DONE;
         jdate_pkg::ST_DONE:  state_in = jdate_pkg::ST_IDLE;
         default:             state_in = jdate_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = jdate_pkg::CMD_NONE;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         jdate_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) cmd = jdate_pkg::CMD_LOAD;
         end
         jdate_pkg::ST_MUL:   cmd = jdate_pkg::CMD_MUL;
         jdate_pkg::ST_BACK:  cmd = jdate_pkg::CMD_BACK;
         jdate_pkg::ST_SUB:   cmd = jdate_pkg::CMD_SUB;
         jdate_pkg::ST_FIX:   if (status.fix_take)   cmd = jdate_pkg::CMD_FIX;
         jdate_pkg::ST_INIT:  cmd = jdate_pkg::CMD_INIT;
         jdate_pkg::ST_CENT:  if (status.cent_take)  cmd = jdate_pkg::CMD_CENT;
         jdate_pkg::ST_QUAD:  if (status.quad_take)  cmd = jdate_pkg::CMD_QUAD;
         jdate_pkg::ST_YEAR:  if (status.year_take)  cmd = jdate_pkg::CMD_YEAR;
         jdate_pkg::ST_MONTH: if (status.month_take) cmd = jdate_pkg::CMD_MONTH;
         jdate_pkg::ST_DONE:  rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jdate_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/julian_day_to_date.sv
// Top level of the converter from a day count since 1 January 4713 BC to a calendar date.
//
// A beat is taken when start is high while busy is low; the block then raises busy and
// works on that one day number until its date is out. The date appears on the rsp_ ports
// for exactly one cycle with rsp_valid high, and the receiver must take it in that cycle,
// as there is no way to hold it off. Counts below 1721424 give a BC year in the Julian
// calendar, counts below 2299161 an AD year in the Julian calendar, and larger counts a
// year of the proleptic Gregorian calendar. From acceptance to the result strobe, the
// states MUL, BACK and SUB divide the count by the length of a 400-year span (Gregorian
// range) or a four-year span (otherwise), by a multiplication with its reciprocal, a
// multiplication back and a subtraction; the FIX state then puts the quotient right, the
// INIT state sets up the year, and the century and four-year spans (Gregorian range
// only), the single years and the months are peeled off one per cycle by compare and
// subtract, each stage ending when its compare fails, before the strobe cycle.
// Busy falls in the cycle after the strobe, so a new beat can be taken then.
module julian_day_to_date (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [jdate_pkg::DAY_W-1:0]    req_day_number,
   output logic                           rsp_valid,
   output logic [4:0]                     rsp_day_of_month,
   output logic [3:0]                     rsp_month_number,
   output logic [jdate_pkg::YEAR_W-1:0]   rsp_year_number,
   output logic                           rsp_before_christ
);

   // Commands flow from the controller to the datapath and status flows back.
   jdate_pkg::cmd_type      cmd;
   jdate_pkg::status_type   status;

   jdate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the result registers, which stay steady through the strobe cycle.
   jdate_dp u_dp (
      .clock             (clock),
      .req_day_number    (req_day_number),
      .cmd               (cmd),
      .status            (status),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_month_number  (rsp_month_number),
      .rsp_year_number   (rsp_year_number),
      .rsp_before_christ (rsp_before_christ)
   );

endmodule
